// ===== rtl/tkst_pkg.sv =====
`timescale 1ns / 1ps
package tkst_pkg;

  localparam int DEPTH      = 8;
  localparam int SCORE_BITS = 32;
  localparam int TAG_BITS   = 24;
  localparam int INDEX_BITS = 3;
  localparam int POS_BITS   = 3;
  localparam int COUNT_BITS = 4;
  localparam int MODE_BITS  = 2;
  localparam int ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ENTRY_BITS = SCORE_BITS + TAG_BITS;

  localparam logic [MODE_BITS-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_CLEAR  = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_READ   = 2'd2;

  typedef struct packed {
    logic [TAG_BITS-1:0]   tag;
    logic [SCORE_BITS-1:0] score;
  } entry_t;

  typedef struct packed {
    logic [MODE_BITS-1:0]  mode;
    logic [SCORE_BITS-1:0] score;
    logic [TAG_BITS-1:0]   tag;
    logic [INDEX_BITS-1:0] index;
  } op_t;

  typedef struct packed {
    logic [TAG_BITS-1:0]   read_tag;
    logic [SCORE_BITS-1:0] read_score;
    logic                  read_valid;
    logic [COUNT_BITS-1:0] entry_count;
    logic [POS_BITS-1:0]   insert_position;
    logic                  inserted;
  } result_t;

endpackage

// ===== rtl/top_k_sorted_insert_table.sv =====
`timescale 1ns / 1ps
// Descending top-k table of score/tag entries kept in one synchronous RAM.
// One operation is handled at a time. Insert walks up from the bottom of the
// table, one RAM read and one write per cycle, moving each lower-scored entry
// down a slot until the new entry's place is found; when the table is full,
// the last entry is checked first. A read below the count waits on the RAM
// read; a read at or past the count, a clear and the unused mode go straight
// to the result.
// The result register frees the input side, so the next transaction is taken
// while a result waits on the output.
module top_k_sorted_insert_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] new_score, [55:32] new_tag, [58:56] read_index, [63:59] zero
  input  logic [63:0] s_axis_tdata,
  // [1:0] mode
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] inserted, [3:1] insert_position, [7:4] entry_count, [8] read_valid,
  // [40:9] read_score, [64:41] read_tag, [71:65] zero
  output logic [71:0] m_axis_tdata
);
  import tkst_pkg::*;

  op_t     op;
  result_t result, out_res;
  logic    idle, done, take, accept;

  assign op.mode  = s_axis_tuser;
  assign op.score = s_axis_tdata[31:0];
  assign op.tag   = s_axis_tdata[55:32];
  assign op.index = s_axis_tdata[58:56];

  assign s_axis_tready = idle;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign take          = done && (!m_axis_tvalid || m_axis_tready);

  tkst_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .op     (op),
    .idle   (idle),
    .done   (done),
    .take   (take),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_res <= result;
  end

  assign m_axis_tdata = {7'd0, out_res};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_res.entry_count <= COUNT_BITS'(DEPTH)))
    else $error("entry count above table depth");

  a_pos_in_table: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_res.inserted) |->
      (COUNT_BITS'(out_res.insert_position) < out_res.entry_count))
    else $error("insert position outside valid entries");

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(out_res.inserted && out_res.read_valid))
    else $error("result marks both insert and read");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_axis_tready)
    else $error("input taken again while an operation is in flight");

endmodule

// ===== rtl/tkst_ram.sv =====
`timescale 1ns / 1ps
module tkst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/tkst_seq.sv =====
`timescale 1ns / 1ps
module tkst_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  tkst_pkg::op_t    op,
  output logic             idle,
  output logic             done,
  input  logic             take,
  output tkst_pkg::result_t result
);
  import tkst_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHK   = 3'd1;
  localparam logic [2:0] ST_SHIFT = 3'd2;
  localparam logic [2:0] ST_WRNEW = 3'd3;
  localparam logic [2:0] ST_RDW   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  localparam logic [ADDR_BITS-1:0]  LAST = ADDR_BITS'(DEPTH - 1);
  localparam logic [COUNT_BITS-1:0] FULL = COUNT_BITS'(DEPTH);

  logic [2:0]            state, state_next;
  logic [COUNT_BITS-1:0] count, count_next;
  logic [ADDR_BITS-1:0]  slot, slot_next;
  op_t                   cur;
  result_t               res, res_next;

  logic                  we, re;
  logic [ADDR_BITS-1:0]  waddr, raddr;
  entry_t                wdata, rdata, new_entry;

  tkst_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign new_entry = '{tag: cur.tag, score: cur.score};
  assign idle      = (state == ST_IDLE);
  assign done      = (state == ST_FIN);
  assign result    = res;

  always_comb begin
    state_next = state;
    count_next = count;
    slot_next  = slot;
    res_next   = res;
    we         = 1'b0;
    waddr      = slot;
    wdata      = new_entry;
    re         = 1'b0;
    raddr      = slot;

    case (state)
      ST_IDLE: begin
        if (start) begin
          res_next = '0;
          case (op.mode)
            MODE_INSERT: begin
              if (count == FULL) begin
                // full table: the last entry decides whether the score gets in
                re         = 1'b1;
                raddr      = LAST;
                state_next = ST_CHK;
              end else if (count == '0) begin
                slot_next  = '0;
                state_next = ST_WRNEW;
              end else begin
                slot_next  = count[ADDR_BITS-1:0];
                re         = 1'b1;
                raddr      = count[ADDR_BITS-1:0] - ADDR_BITS'(1);
                state_next = ST_SHIFT;
              end
            end
            MODE_CLEAR: begin
              count_next           = '0;
              res_next.entry_count = '0;
              state_next           = ST_FIN;
            end
            MODE_READ: begin
              if (COUNT_BITS'(op.index) < count) begin
                re         = 1'b1;
                raddr      = op.index[ADDR_BITS-1:0];
                state_next = ST_RDW;
              end else begin
                res_next.entry_count = count;
                state_next           = ST_FIN;
              end
            end
            default: begin
              res_next.entry_count = count;
              state_next           = ST_FIN;
            end
          endcase
        end
      end

      ST_CHK: begin
        if (rdata.score >= cur.score) begin
          res_next.entry_count = count;
          state_next           = ST_FIN;
        end else if (LAST == '0) begin
          slot_next  = '0;
          state_next = ST_WRNEW;
        end else begin
          slot_next  = LAST;
          re         = 1'b1;
          raddr      = LAST - ADDR_BITS'(1);
          state_next = ST_SHIFT;
        end
      end

      // rdata holds the entry just above slot; move it down or drop the new one in
      ST_SHIFT: begin
        we    = 1'b1;
        waddr = slot;
        if (rdata.score >= cur.score) begin
          wdata                    = new_entry;
          if (count != FULL) count_next = count + COUNT_BITS'(1);
          res_next.inserted        = 1'b1;
          res_next.insert_position = POS_BITS'(slot);
          res_next.entry_count     = (count != FULL) ? count + COUNT_BITS'(1) : count;
          state_next               = ST_FIN;
        end else begin
          wdata     = rdata;
          slot_next = slot - ADDR_BITS'(1);
          if (slot == ADDR_BITS'(1)) begin
            state_next = ST_WRNEW;
          end else begin
            re    = 1'b1;
            raddr = slot - ADDR_BITS'(2);
          end
        end
      end

      ST_WRNEW: begin
        we                       = 1'b1;
        waddr                    = slot;
        wdata                    = new_entry;
        if (count != FULL) count_next = count + COUNT_BITS'(1);
        res_next.inserted        = 1'b1;
        res_next.insert_position = POS_BITS'(slot);
        res_next.entry_count     = (count != FULL) ? count + COUNT_BITS'(1) : count;
        state_next               = ST_FIN;
      end

      ST_RDW: begin
        res_next.read_valid  = 1'b1;
        res_next.read_score  = rdata.score;
        res_next.read_tag    = rdata.tag;
        res_next.entry_count = count;
        state_next           = ST_FIN;
      end

      ST_FIN: begin
        if (take) state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
    res  <= res_next;
    if (start && idle) begin
      cur <= op;
    end
  end

endmodule

// ===== dv/top_k_sorted_insert_table_test.sv =====
`timescale 1ns / 1ps
module top_k_sorted_insert_table_test;
  import tkst_pkg::*;

  localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;
  localparam int MAX_GAP     = 17;
  localparam int RANDOM_OPS  = 800;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = DEPTH + 8;

  typedef struct {
    logic [MODE_BITS-1:0]  mode;
    logic [SCORE_BITS-1:0] score;
    logic [TAG_BITS-1:0]   tag;
    logic [INDEX_BITS-1:0] index;
    int                    gap;
    bit                    drain;
  } table_op_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [31:0] new_score, [55:32] new_tag, [58:56] read_index, [63:59] zero
  logic [63:0] s_axis_tdata = '0;
  // [1:0] mode
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [0] inserted, [3:1] insert_position, [7:4] entry_count, [8] read_valid,
  // [40:9] read_score, [64:41] read_tag, [71:65] zero
  logic [71:0] m_axis_tdata;

  top_k_sorted_insert_table DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the table
  logic [SCORE_BITS-1:0] shadow_score [DEPTH];
  logic [TAG_BITS-1:0]   shadow_tag   [DEPTH];
  int                    shadow_count = 0;

  table_op_t pending_ops[$];
  result_t   expected_results[$];

  int errors = 0;
  int cycles = 0;
  int n_inserted = 0, n_rejected = 0, n_read_hit = 0, n_read_miss = 0;
  int n_clear = 0, n_noop = 0, n_full_seen = 0;

  function automatic result_t apply_table_op(table_op_t op);
    result_t r;
    int pos;
    int last;
    r = '0;
    case (op.mode)
      MODE_INSERT: begin
        pos = 0;
        while (pos < shadow_count && shadow_score[pos] >= op.score)
          pos++;
        if (pos < DEPTH) begin
          last = (shadow_count < DEPTH) ? shadow_count : DEPTH - 1;
          for (int k = last; k > pos; k--) begin
            shadow_score[k] = shadow_score[k-1];
            shadow_tag[k]   = shadow_tag[k-1];
          end
          shadow_score[pos] = op.score;
          shadow_tag[pos]   = op.tag;
          if (shadow_count < DEPTH)
            shadow_count++;
          r.inserted        = 1'b1;
          r.insert_position = pos[POS_BITS-1:0];
          n_inserted++;
        end else begin
          n_rejected++;
        end
        if (shadow_count == DEPTH)
          n_full_seen++;
      end
      MODE_CLEAR: begin
        shadow_count = 0;
        n_clear++;
      end
      MODE_READ: begin
        if (op.index < shadow_count) begin
          r.read_valid = 1'b1;
          r.read_score = shadow_score[op.index];
          r.read_tag   = shadow_tag[op.index];
          n_read_hit++;
        end else begin
          n_read_miss++;
        end
      end
      default: n_noop++;
    endcase
    r.entry_count = shadow_count[COUNT_BITS-1:0];
    return r;
  endfunction

  // Driver
  int        send_wait = 0;
  table_op_t cur_op;
  logic      next_valid;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_wait = 0;
    end else begin
      next_valid = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(apply_table_op(cur_op));
        next_valid = 1'b0;
      end
      if (!next_valid && pending_ops.size() != 0) begin
        if (send_wait < pending_ops[0].gap) begin
          send_wait++;
        end else if (!(pending_ops[0].drain && expected_results.size() != 0)) begin
          cur_op = pending_ops.pop_front();
          s_axis_tdata <= {5'b0, cur_op.index, cur_op.tag, cur_op.score};
          s_axis_tuser <= cur_op.mode;
          next_valid = 1'b1;
          send_wait = 0;
        end
      end
      s_axis_tvalid <= next_valid;
    end
  end

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $realtime, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Monitor
  int      stall_left = 0;
  int      results_seen = 0;
  bit      quiet_recv = 0;
  result_t exp_r;
  result_t act_r;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        act_r = result_t'(m_axis_tdata[64:0]);
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $realtime, m_axis_tdata);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("inserted", exp_r.inserted, act_r.inserted);
          check_field("insert_position", exp_r.insert_position, act_r.insert_position);
          check_field("entry_count", exp_r.entry_count, act_r.entry_count);
          check_field("read_valid", exp_r.read_valid, act_r.read_valid);
          check_field("read_score", exp_r.read_score, act_r.read_score);
          check_field("read_tag", exp_r.read_tag, act_r.read_tag);
          check_field("tdata padding", '0, m_axis_tdata[71:65]);
        end
        results_seen++;
        if (results_seen % 64 == 0)
          quiet_recv = ($urandom_range(0, 2) == 0);
        stall_left = quiet_recv ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $realtime,
               expected_results.size());
      $display("top_k_sorted_insert_table_test NOT OK");
      $finish;
    end
  end

  task automatic add_op(logic [MODE_BITS-1:0] mode, logic [SCORE_BITS-1:0] score,
                        logic [TAG_BITS-1:0] tag, logic [INDEX_BITS-1:0] index,
                        int gap, bit drain);
    table_op_t op;
    op.mode  = mode;
    op.score = score;
    op.tag   = tag;
    op.index = index;
    op.gap   = gap;
    op.drain = drain;
    pending_ops.push_back(op);
  endtask

  initial begin
    int r;
    int gap;
    bit quiet_send;
    logic [MODE_BITS-1:0]  mode;
    logic [SCORE_BITS-1:0] score;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: empty read, extremes, ties, fill, rejects, clear
    add_op(MODE_READ,   '0,            '0,          3'd0, 0, 0);
    add_op(MODE_INSERT, '0,            '0,          '0,   0, 0);
    add_op(MODE_INSERT, '1,            '1,          '1,   1, 0);
    add_op(MODE_INSERT, 32'd100,       24'hAAAAAA,  3'd5, 0, 0);
    add_op(MODE_INSERT, 32'd100,       24'h555555,  3'd2, 3, 0);
    add_op(MODE_READ,   '1,            '1,          3'd2, 0, 0);
    add_op(MODE_READ,   '0,            '0,          3'd3, 0, 0);
    add_op(MODE_UNUSED, 32'h12345678,  24'h9ABCDE,  '1,   2, 0);
    add_op(MODE_INSERT, 32'd50,        24'h000001,  3'd0, 0, 0);
    add_op(MODE_INSERT, 32'd70,        24'h000002,  3'd0, 0, 0);
    add_op(MODE_INSERT, 32'd90,        24'h000003,  3'd0, 0, 0);
    add_op(MODE_INSERT, 32'd200,       24'h000004,  3'd0, 0, 0);
    // table is full now, last entry scores 0
    add_op(MODE_INSERT, '0,            24'hFACE00,  3'd0, 0, 0);
    add_op(MODE_INSERT, 32'd1,         24'hFACE01,  3'd0, 0, 0);
    add_op(MODE_INSERT, '1,            24'hFACE02,  3'd0, 5, 0);
    add_op(MODE_READ,   '0,            '0,          3'd7, 0, 0);
    add_op(MODE_READ,   '0,            '0,          3'd1, 0, 0);
    add_op(MODE_CLEAR,  '1,            '1,          '1,   0, 1);
    add_op(MODE_READ,   '0,            '0,          3'd0, 0, 0);
    add_op(MODE_INSERT, 32'h80000000,  24'h800000,  3'd4, 0, 0);
    add_op(MODE_READ,   '0,            '0,          3'd1, 0, 0);
    add_op(MODE_READ,   '0,            '0,          3'd0, 0, 0);

    quiet_send = 0;
    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (i % 50 == 0)
        quiet_send = ($urandom_range(0, 2) == 0);
      gap = quiet_send ? 0 : $urandom_range(0, MAX_GAP);
      r = $urandom_range(0, 99);
      if (r < 55)      mode = MODE_INSERT;
      else if (r < 92) mode = MODE_READ;
      else if (r < 96) mode = MODE_CLEAR;
      else             mode = MODE_UNUSED;
      // narrow score pools give plenty of ties and rejects
      case ($urandom_range(0, 3))
        0:       score = $urandom_range(0, 15);
        1:       score = 32'hFFFF_FFF0 | $urandom_range(0, 15);
        default: score = $urandom;
      endcase
      add_op(mode, score, TAG_BITS'($urandom), INDEX_BITS'($urandom_range(0, 7)), gap,
             (i % 97 == 96));
    end

    while (pending_ops.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $realtime,
               expected_results.size());
      errors++;
    end
    $display("Ran %0d transactions: %0d inserts taken, %0d rejected, %0d full-table states",
             results_seen, n_inserted, n_rejected, n_full_seen);
    $display("  reads hit %0d, reads past count %0d, clears %0d, unused mode %0d, errors %0d",
             n_read_hit, n_read_miss, n_clear, n_noop, errors);
    if (errors == 0) begin
      $display("top_k_sorted_insert_table_test OK");
    end else begin
      $display("top_k_sorted_insert_table_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tkst_pkg.sv
rtl/tkst_ram.sv
rtl/tkst_seq.sv
rtl/top_k_sorted_insert_table.sv
dv/top_k_sorted_insert_table_test.sv
